[rtl/core/sblfp_pkg.sv]
// Shared types and constants for the start-byte length-prefixed frame parser.
package sblfp_pkg;

    localparam int HEADER_BYTES = 6;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD
    } phase_t;

    typedef enum logic [2:0] {
        HP_SRC_LO,
        HP_SRC_HI,
        HP_TYPE,
        HP_SEQ,
        HP_FLAGS,
        HP_RADIUS
    } hdr_pos_t;

    typedef struct packed {
        logic       cap;
        hdr_pos_t   pos;
        logic       emit;
        logic       has_data;
        logic       last;
        logic       status;
        logic [7:0] byte_val;
    } cmd_t;

endpackage

[rtl/core/start_byte_length_frame_parser_top.sv]
// Top level of the start-byte length-prefixed frame parser.
// Throughput: one byte per cycle; in_stall rises only when the 4-beat command queue is full.
// A byte that yields a result is classified in the cycle it is accepted, written into the command queue,
// then loaded from the queue head into the output register that drives out_valid.
// Reset: rst_n clears phase, length, index, header fields, marker (to 0) and the queue.
module start_byte_length_frame_parser_top
    import sblfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  data_byte,
    output logic        has_data,
    output logic        last,
    output logic        status,
    output logic [15:0] origin_id,
    output logic [7:0]  msg_type,
    output logic [7:0]  seq_num,
    output logic [7:0]  flag_bits,
    output logic [7:0]  hop_radius
);

    logic acc;
    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    assign in_stall = full;
    assign acc      = in_valid && !full;

    sblfp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .acc         (acc),
        .in_byte     (in_byte),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    sblfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    sblfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_byte  (data_byte),
        .has_data   (has_data),
        .last       (last),
        .status     (status),
        .origin_id  (origin_id),
        .msg_type   (msg_type),
        .seq_num    (seq_num),
        .flag_bits  (flag_bits),
        .hop_radius (hop_radius)
    );

endmodule

[rtl/core/sblfp_front.sv]
// Front end: marker hunt, length capture and classification of each byte.
module sblfp_front
    import sblfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       acc,
    input  logic [7:0] in_byte,
    output logic       push,
    output cmd_t       push_cmd
);

    phase_t      phase_reg, phase_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] idx_reg, idx_next;
    logic [7:0]  marker_reg;

    logic [16:0] idx_inc;
    logic        at_end;
    logic        in_hdr;
    logic        below_hdr;

    assign idx_inc   = {1'b0, idx_reg} + 17'd1;
    assign at_end    = idx_inc >= {1'b0, len_reg};
    assign in_hdr    = idx_reg < 16'(HEADER_BYTES);
    assign below_hdr = idx_inc < 17'(HEADER_BYTES);

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        if (acc)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (in_byte == marker_reg)
                        phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next   = {8'h00, in_byte};
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    len_next   = {in_byte, len_reg[7:0]};
                    idx_next   = '0;
                    phase_next = ({in_byte, len_reg[7:0]} == 16'h0000) ? PH_HUNT : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    idx_next = idx_inc[15:0];
                    if (at_end)
                        phase_next = PH_HUNT;
                end
                default:
                    phase_next = PH_HUNT;
            endcase
        end
    end

    always_comb
    begin
        push              = 1'b0;
        push_cmd          = '0;
        push_cmd.pos      = hdr_pos_t'(idx_reg[2:0]);
        push_cmd.byte_val = in_byte;
        if (acc)
        begin
            unique case (phase_reg)
                PH_LEN_HI:
                begin
                    if ({in_byte, len_reg[7:0]} == 16'h0000)
                    begin
                        push            = 1'b1;
                        push_cmd.emit   = 1'b1;
                        push_cmd.last   = 1'b1;
                        push_cmd.status = 1'b1;
                    end
                end
                PH_PAYLOAD:
                begin
                    push         = 1'b1;
                    push_cmd.cap = in_hdr;
                    if (at_end)
                    begin
                        push_cmd.emit     = 1'b1;
                        push_cmd.last     = 1'b1;
                        push_cmd.status   = below_hdr;
                        push_cmd.has_data = !below_hdr && !in_hdr;
                    end
                    else
                    begin
                        push_cmd.emit     = !in_hdr;
                        push_cmd.has_data = !in_hdr;
                    end
                end
                default:
                    push = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            len_reg    <= '0;
            idx_reg    <= '0;
            marker_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            if (cfg_wr_en)
                marker_reg <= cfg_wr_data;
        end
    end

endmodule

[rtl/core/sblfp_queue.sv]
// Short command queue between front end and back end.
module sblfp_queue
    import sblfp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign full       = cnt_reg == QCNT_W'(QDEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + QCNT_W'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - QCNT_W'(1);
        end
    end

endmodule

[rtl/core/sblfp_back.sv]
// Back end: header capture and result output register.
module sblfp_back
    import sblfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  cmd_t        head_cmd,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  data_byte,
    output logic        has_data,
    output logic        last,
    output logic        status,
    output logic [15:0] origin_id,
    output logic [7:0]  msg_type,
    output logic [7:0]  seq_num,
    output logic [7:0]  flag_bits,
    output logic [7:0]  hop_radius
);

    logic [15:0] src_reg, src_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  flags_reg, flags_next;
    logic [7:0]  radius_reg, radius_next;

    logic        ov_reg;
    logic [7:0]  o_data_reg;
    logic        o_has_reg, o_last_reg, o_status_reg;
    logic [15:0] o_src_reg;
    logic [7:0]  o_type_reg, o_seq_reg, o_flags_reg, o_radius_reg;

    logic        load;

    assign pop  = head_valid && (!head_cmd.emit || !ov_reg || !out_stall);
    assign load = pop && head_cmd.emit;

    always_comb
    begin
        src_next    = src_reg;
        type_next   = type_reg;
        seq_next    = seq_reg;
        flags_next  = flags_reg;
        radius_next = radius_reg;
        if (pop && head_cmd.cap)
        begin
            unique case (head_cmd.pos)
                HP_SRC_LO: src_next[7:0]  = head_cmd.byte_val;
                HP_SRC_HI: src_next[15:8] = head_cmd.byte_val;
                HP_TYPE:   type_next      = head_cmd.byte_val;
                HP_SEQ:    seq_next       = head_cmd.byte_val;
                HP_FLAGS:  flags_next     = head_cmd.byte_val;
                HP_RADIUS: radius_next    = head_cmd.byte_val;
                default:   src_next       = src_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg    <= '0;
            type_reg   <= '0;
            seq_reg    <= '0;
            flags_reg  <= '0;
            radius_reg <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            src_reg    <= src_next;
            type_reg   <= type_next;
            seq_reg    <= seq_next;
            flags_reg  <= flags_next;
            radius_reg <= radius_next;
            if (load)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            o_data_reg   <= head_cmd.has_data ? head_cmd.byte_val : 8'h00;
            o_has_reg    <= head_cmd.has_data;
            o_last_reg   <= head_cmd.last;
            o_status_reg <= head_cmd.status;
            o_src_reg    <= head_cmd.status ? 16'h0000 : src_next;
            o_type_reg   <= head_cmd.status ? 8'h00 : type_next;
            o_seq_reg    <= head_cmd.status ? 8'h00 : seq_next;
            o_flags_reg  <= head_cmd.status ? 8'h00 : flags_next;
            o_radius_reg <= head_cmd.status ? 8'h00 : radius_next;
        end
    end

    assign out_valid  = ov_reg;
    assign data_byte  = o_data_reg;
    assign has_data   = o_has_reg;
    assign last       = o_last_reg;
    assign status     = o_status_reg;
    assign origin_id  = o_src_reg;
    assign msg_type   = o_type_reg;
    assign seq_num    = o_seq_reg;
    assign flag_bits  = o_flags_reg;
    assign hop_radius = o_radius_reg;

endmodule

[rtl/core/sblfp_checker.sv]
// Port-level assertions for the frame parser, bound to the top level.
module sblfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  data_byte,
    input logic        has_data,
    input logic        last,
    input logic        status,
    input logic [15:0] origin_id,
    input logic [7:0]  msg_type,
    input logic [7:0]  seq_num,
    input logic [7:0]  flag_bits,
    input logic [7:0]  hop_radius
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(last))
        else $error("stalled result beat changed");

    a_short_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> last && !has_data && data_byte == 8'h00)
        else $error("short-frame beat malformed");

    a_short_hdr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> origin_id == 16'h0000 && msg_type == 8'h00
            && seq_num == 8'h00 && flag_bits == 8'h00 && hop_radius == 8'h00)
        else $error("short-frame beat carries header fields");

    a_nodata_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_data |-> last && data_byte == 8'h00)
        else $error("beat without data does not end the frame");

endmodule

bind start_byte_length_frame_parser_top sblfp_checker u_sblfp_checker (.*);
